[rtl/hll_pkg.sv]
// shared constants and beat types for the hyperloglog register update block
package hll_pkg;

    // sketch geometry
    localparam int INDEX_BITS = 10;
    localparam int REG_COUNT  = 1 << INDEX_BITS;
    localparam int HASH_W     = 32;
    localparam int REM_BITS   = HASH_W - INDEX_BITS;
    localparam int RANK_W     = 5;

    // fixed point sum: fraction bits and widths
    localparam int Q_FRAC    = 32;
    localparam int SUM_W     = 43;
    localparam int SUM_INT_W = INDEX_BITS + Q_FRAC + 1;
    localparam int ZERO_W    = 11;
    localparam int ZCNT_W    = INDEX_BITS + 1;

    // queue between front and back
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // function codes
    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // input beat
    typedef struct packed {
        logic              func;
        logic [HASH_W-1:0] hash_word;
    } req_t;

    // result beat
    typedef struct packed {
        logic [SUM_W-1:0]  harmonic_sum;
        logic [ZERO_W-1:0] zero_registers;
    } rsp_t;

    // classified operation carried through the queue
    typedef struct packed {
        logic                  is_query;
        logic [INDEX_BITS-1:0] idx;
        logic [RANK_W-1:0]     rank;
    } op_t;

    // queue write side
    typedef struct packed {
        logic valid;
        op_t  op;
    } push_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic valid;
        op_t  op;
    } head_t;

    // queue and back end status seen by the front end
    typedef struct packed {
        logic full;
        logic clearing;
    } fe_status_t;

endpackage

[rtl/hll_front.sv]
// front end: accepts beats, splits hash into register index and rank
module hll_front
    import hll_pkg::*;
(
    input  logic       req_valid,
    output logic       req_stall,
    input  req_t       req,
    input  fe_status_t status,
    output push_t      push
);

    // rank = leading zero count of the remaining bits plus one, capped at width plus one
    function automatic logic [RANK_W-1:0] rank_of(input logic [REM_BITS-1:0] rem);
        logic [RANK_W-1:0] r;
        r = RANK_W'(REM_BITS + 1);
        for (int i = 0; i < REM_BITS; i++)
        begin
            if (rem[i])
            begin
                r = RANK_W'(REM_BITS - i);
            end
        end
        return r;
    endfunction

    // hold off while the store is being cleared or the queue is full
    assign req_stall = status.clearing | status.full;

    // classify and push
    always_comb
    begin
        push.valid       = req_valid & ~req_stall;
        push.op.is_query = (req.func == FUNC_QUERY);
        push.op.idx      = req.hash_word[HASH_W-1 -: INDEX_BITS];
        push.op.rank     = rank_of(req.hash_word[REM_BITS-1:0]);
    end

endmodule

[rtl/hll_queue.sv]
// short fifo of classified operations between front and back end
module hll_queue
    import hll_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    output logic  full,
    output head_t head,
    input  logic  pop
);

    op_t               entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head.valid = (count_reg != '0);
    assign head.op    = entry_reg[rd_ptr_reg];

    assign do_push = push.valid & ~full;
    assign do_pop  = pop & head.valid;

    // pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push & ~do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop & ~do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.op;
        end
    end

endmodule

[rtl/hll_back.sv]
// back end: rank store read-modify-write, running sum, zero count, result register
module hll_back
    import hll_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  head_t head,
    output logic  pop,
    output logic  clearing,
    output logic  rsp_valid,
    input  logic  rsp_stall,
    output rsp_t  rsp
);

    localparam int CLR_W = INDEX_BITS + 1;
    localparam logic [SUM_INT_W-1:0] SUM_RESET = SUM_INT_W'(REG_COUNT) << Q_FRAC;
    localparam logic [ZCNT_W-1:0]    ZCNT_RESET = ZCNT_W'(REG_COUNT);

    // 2^-rank in q.32
    function automatic logic [SUM_INT_W-1:0] q32_term(input logic [RANK_W-1:0] r);
        logic [5:0] sh;
        sh = 6'(Q_FRAC) - 6'(r);
        return SUM_INT_W'(1) << sh;
    endfunction

    logic [RANK_W-1:0]     mem [REG_COUNT];
    logic [RANK_W-1:0]     rd_data_reg;
    logic                  b_valid_reg;
    op_t                   b_op_reg;
    logic                  lw_valid_reg;
    logic [INDEX_BITS-1:0] lw_idx_reg;
    logic [RANK_W-1:0]     lw_val_reg;
    logic [SUM_INT_W-1:0]  sum_reg;
    logic [SUM_INT_W-1:0]  sum_next;
    logic [ZCNT_W-1:0]     zcnt_reg;
    logic [ZCNT_W-1:0]     zcnt_next;
    logic [CLR_W-1:0]      clr_cnt_reg;
    logic                  out_valid_reg;
    rsp_t                  out_item_reg;
    logic                  out_free;
    logic                  b_done;
    logic                  b_adv;
    logic [RANK_W-1:0]     old_rank;
    logic                  grow;
    logic                  wr_en;
    logic [INDEX_BITS-1:0] wr_addr;
    logic [RANK_W-1:0]     wr_data;

    assign clearing = ~clr_cnt_reg[INDEX_BITS];

    // stage advance: a query waits for the result register
    assign out_free = ~out_valid_reg | ~rsp_stall;
    assign b_done   = b_valid_reg & (~b_op_reg.is_query | out_free);
    assign b_adv    = ~b_valid_reg | b_done;
    assign pop      = head.valid & b_adv & ~clearing;

    // old rank with forwarding of the write that the read just missed
    assign old_rank = (lw_valid_reg && lw_idx_reg == b_op_reg.idx) ? lw_val_reg : rd_data_reg;
    assign grow     = b_valid_reg & ~b_op_reg.is_query & (b_op_reg.rank > old_rank);

    // single write port shared by the clearing sweep and updates
    assign wr_en   = clearing | grow;
    assign wr_addr = clearing ? clr_cnt_reg[INDEX_BITS-1:0] : b_op_reg.idx;
    assign wr_data = clearing ? '0 : b_op_reg.rank;

    // sum and zero count update
    always_comb
    begin
        sum_next  = sum_reg;
        zcnt_next = zcnt_reg;
        if (grow)
        begin
            sum_next = sum_reg - q32_term(old_rank) + q32_term(b_op_reg.rank);
            if (old_rank == '0 && zcnt_reg != '0)
            begin
                zcnt_next = zcnt_reg - ZCNT_W'(1);
            end
        end
    end

    // rank store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (pop)
        begin
            rd_data_reg <= mem[head.op.idx];
        end
    end

    // control and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            b_valid_reg   <= 1'b0;
            lw_valid_reg  <= 1'b0;
            sum_reg       <= SUM_RESET;
            zcnt_reg      <= ZCNT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clearing)
            begin
                clr_cnt_reg <= clr_cnt_reg + CLR_W'(1);
            end
            if (b_adv)
            begin
                b_valid_reg <= pop;
            end
            lw_valid_reg <= grow;
            sum_reg      <= sum_next;
            zcnt_reg     <= zcnt_next;
            if (b_done && b_op_reg.is_query)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b_op_reg <= head.op;
        end
        lw_idx_reg <= b_op_reg.idx;
        lw_val_reg <= b_op_reg.rank;
        if (b_done && b_op_reg.is_query)
        begin
            out_item_reg.harmonic_sum   <= SUM_W'(sum_reg);
            out_item_reg.zero_registers <= ZERO_W'(zcnt_reg);
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_item_reg;

    // no operation reaches the update stage during the clearing sweep
    a_no_op_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !b_valid_reg)
        else $error("operation in update stage during clearing");

    // zero count never exceeds the register count
    a_zcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        zcnt_reg <= ZCNT_RESET)
        else $error("zero count above register count");

    // the sum moves only when a register grows
    a_sum_only_on_grow: assert property (@(posedge clk) disable iff (!rst_n)
        !grow |=> $stable(sum_reg))
        else $error("sum changed without a register update");

    // a new result only follows a query in the update stage
    a_rsp_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(b_valid_reg && b_op_reg.is_query))
        else $error("result raised without a query");

    // the stage holding a query keeps it while the result register is blocked
    a_query_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && b_op_reg.is_query && !out_free) |=> (b_valid_reg && b_op_reg.is_query))
        else $error("blocked query left the update stage");

endmodule

[rtl/hyperloglog_register_update_top.sv]
// top level of the hyperloglog register update block
//
// req channel: one beat per hash word (func add) or per query (func query);
// a beat is taken at a clock edge with req_valid high and req_stall low.
// rsp channel: one beat per query carrying the q.32 harmonic sum of 2^-rank
// over all rank registers and the number of registers still at zero; adds
// give no beat. Same valid/stall rule as req.
// throughput: one beat per cycle while rsp_stall is low and no clearing
// sweep runs, adds and queries mixed in any order; the rank store is read
// for each operation and written when a rank grows, and a write the read
// just missed is forwarded from the previous update. A query beat passes
// through the queue, the update stage and the result register to rsp.
// a query sees every add accepted before it.
// reset: rst_n low clears control state, sets the sum to the register count
// in q.32 and the zero count to the register count; then a sweep of all 1024
// rank registers, one at a time, zeroes the rank store, with req_stall high.
// receiver stall: the result register holds its beat; a query behind it waits
// in the update stage and the two-entry queue, and req_stall rises when the
// queue fills.
module hyperloglog_register_update_top
    import hll_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    push_t      push;
    head_t      head;
    fe_status_t status;
    logic       q_full;
    logic       pop;
    logic       clearing;

    assign status.full     = q_full;
    assign status.clearing = clearing;

    // classify incoming beats
    hll_front u_front (
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .status    (status),
        .push      (push)
    );

    // decouple front and back
    hll_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .head  (head),
        .pop   (pop)
    );

    // update rank store and accumulators, emit query results
    hll_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .clearing  (clearing),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
